/* design/ehash_pkg.sv */
// Package for the extendible hash table: sizes, codes, and the controller
// and datapath command/status types. It has no dependencies.
package ehash_pkg;

  localparam int MAX_DEPTH = 6;
  localparam int SLOTS     = 8;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int DIR_W     = MAX_DEPTH;
  localparam int DIR_N     = 1 << MAX_DEPTH;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int KV_AW     = DIR_W + SLOT_W;
  localparam int USED_W    = $clog2(SLOTS + 1);
  localparam int CAP_W     = 4;
  localparam int DEPTH_W   = 3;
  localparam int COUNT_W   = 7;

  localparam logic [1:0] CMD_FIND   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  // The spare command code behaves as a find.
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISSING  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_DIR_RD, OP_BKT_RD, OP_ROW_LATCH,
    OP_SLOT_RD, OP_SLOT_CMP, OP_FIND_DONE, OP_REMOVE, OP_OVERWRITE,
    OP_STORE, OP_FULL, OP_SPLIT_BEGIN, OP_DBL_RD, OP_DBL_WR, OP_NEW_LD,
    OP_MOVE_RD, OP_MOVE_WR, OP_ROW_WR_OLD, OP_ROW_WR_NEW, OP_RP_RD, OP_RP_WR
  } dp_op_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DIR, S_BKT, S_LATCH, S_SRD, S_SCMP, S_DECIDE,
    S_DRD, S_DWR, S_NLD, S_MRD, S_MWR, S_WOLD, S_WNEW, S_PRD, S_PWR
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       hit;
    logic       room;
    logic       at_limit;
    logic       grow;
    logic       slot_last;
    logic       i_last;
    logic       out_free;
  } dp_status_t;

  // Directory index mask for a given global depth.
  function automatic logic [DIR_W-1:0] dir_mask(input logic [DEPTH_W-1:0] depth);
    logic [DIR_W:0] full;
    full = ({{DIR_W{1'b0}}, 1'b1} << depth) - {{DIR_W{1'b0}}, 1'b1};
    return full[DIR_W-1:0];
  endfunction

endpackage

/* design/ehash_ctrl.sv */
// Controller state machine of the extendible hash table.
// Depends on ehash_pkg; drives the datapath through dp_cmd_t.
module ehash_ctrl
  import ehash_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t stat,
  output dp_cmd_t    ctl
);

  ctl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    case (state)
      S_INIT: begin
        ctl.op     = OP_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = OP_LOAD;
          state_next = S_DIR;
        end
      end
      S_DIR: begin
        ctl.op     = OP_DIR_RD;
        state_next = S_BKT;
      end
      S_BKT: begin
        ctl.op     = OP_BKT_RD;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        ctl.op     = OP_ROW_LATCH;
        state_next = S_SRD;
      end
      S_SRD: begin
        ctl.op     = OP_SLOT_RD;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        ctl.op     = OP_SLOT_CMP;
        state_next = stat.slot_last ? S_DECIDE : S_SRD;
      end
      S_DECIDE: begin
        if (stat.cmd == CMD_INSERT && !stat.hit && !stat.room && !stat.at_limit) begin
          ctl.op     = OP_SPLIT_BEGIN;
          state_next = stat.grow ? S_DRD : S_NLD;
        end else if (stat.out_free) begin
          state_next = S_IDLE;
          case (stat.cmd)
            CMD_INSERT: ctl.op = stat.hit ? OP_OVERWRITE : (stat.room ? OP_STORE : OP_FULL);
            CMD_REMOVE: ctl.op = OP_REMOVE;
            default:    ctl.op = OP_FIND_DONE;
          endcase
        end
      end
      S_DRD: begin
        ctl.op     = OP_DBL_RD;
        state_next = S_DWR;
      end
      S_DWR: begin
        ctl.op     = OP_DBL_WR;
        state_next = stat.i_last ? S_NLD : S_DRD;
      end
      S_NLD: begin
        ctl.op     = OP_NEW_LD;
        state_next = S_MRD;
      end
      S_MRD: begin
        ctl.op     = OP_MOVE_RD;
        state_next = S_MWR;
      end
      S_MWR: begin
        ctl.op     = OP_MOVE_WR;
        state_next = stat.slot_last ? S_WOLD : S_MRD;
      end
      S_WOLD: begin
        ctl.op     = OP_ROW_WR_OLD;
        state_next = S_WNEW;
      end
      S_WNEW: begin
        ctl.op     = OP_ROW_WR_NEW;
        state_next = S_PRD;
      end
      S_PRD: begin
        ctl.op     = OP_RP_RD;
        state_next = S_PWR;
      end
      S_PWR: begin
        ctl.op     = OP_RP_WR;
        state_next = stat.i_last ? S_DIR : S_PRD;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

/* design/ehash_dp.sv */
// Datapath of the extendible hash table: directory, local depth, slot
// occupancy and key/value memories, scan and split counters, result register.
// Depends on ehash_pkg; sequenced by ehash_ctrl.
module ehash_dp
  import ehash_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            ctl,
  output dp_status_t         stat,
  input  logic               cfg_wr_en,
  input  logic [CAP_W-1:0]   cfg_wr_data,
  input  logic [1:0]         command,
  input  logic [KEY_W-1:0]   key,
  input  logic [VAL_W-1:0]   write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [VAL_W-1:0]   read_value,
  output logic [DEPTH_W-1:0] global_depth,
  output logic [COUNT_W-1:0] bucket_count
);

  // Memories.
  logic [DIR_W-1:0]         dir_mem [DIR_N];
  logic [DEPTH_W-1:0]       ld_mem  [DIR_N];
  logic [SLOTS-1:0]         row_mem [DIR_N];
  logic [KEY_W+VAL_W-1:0]   kv_mem  [DIR_N*SLOTS];

  logic [DIR_W-1:0]         dir_rdata, dir_ra, dir_wa, dir_wd;
  logic                     dir_we;
  logic [DEPTH_W-1:0]       ld_rdata, ld_wd;
  logic [DIR_W-1:0]         ld_ra, ld_wa;
  logic                     ld_we;
  logic [SLOTS-1:0]         row_rdata, row_wd;
  logic [DIR_W-1:0]         row_ra, row_wa;
  logic                     row_we;
  logic [KEY_W+VAL_W-1:0]   kv_rdata, kv_wd;
  logic [KV_AW-1:0]         kv_ra, kv_wa;
  logic                     kv_we;

  // Working registers.
  logic [1:0]         cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   val_q;
  logic [DIR_W-1:0]   b, nb, i;
  logic [SLOTS-1:0]   row_q, new_row;
  logic [DEPTH_W-1:0] ldb, depth;
  logic [SLOT_W-1:0]  s, put, hit_slot, free_slot;
  logic               hit, free_found;
  logic [VAL_W-1:0]   hit_val;
  logic [USED_W-1:0]  used;
  logic [COUNT_W-1:0] bcount;
  logic [CAP_W-1:0]   cap;

  logic [CAP_W-1:0]   eff_cap;
  logic [DIR_W-1:0]   len;
  logic [KEY_W-1:0]   kv_key;
  logic               move_hit, slot_match, result_op;

  assign kv_key   = kv_rdata[KEY_W+VAL_W-1:VAL_W];
  assign len      = DIR_W'({{DIR_W{1'b0}}, 1'b1} << depth);
  assign move_hit = row_q[s] && kv_key[{2'b00, ldb}];
  assign slot_match = row_q[s] && (kv_key == key_q);
  assign eff_cap  = (cap == '0) ? CAP_W'(1) :
                    ((cap > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : cap);
  assign result_op = (ctl.op == OP_FIND_DONE) || (ctl.op == OP_REMOVE) ||
                     (ctl.op == OP_OVERWRITE) || (ctl.op == OP_STORE) ||
                     (ctl.op == OP_FULL);

  // Status towards the controller.
  always_comb begin
    stat.cmd       = cmd_q;
    stat.hit       = hit;
    stat.room      = free_found && (CAP_W'(used) < eff_cap);
    stat.at_limit  = (ldb >= DEPTH_W'(MAX_DEPTH));
    stat.grow      = (ldb == depth);
    stat.slot_last = (s == SLOT_W'(SLOTS - 1));
    stat.i_last    = (i == dir_mask(depth));
    stat.out_free  = !out_valid || !out_stall;
  end

  // Memory port selection for the current operation.
  always_comb begin
    dir_ra = i;  dir_we = 1'b0; dir_wa = i;  dir_wd = '0;
    ld_ra  = b;  ld_we  = 1'b0; ld_wa  = b;  ld_wd  = ldb + DEPTH_W'(1);
    row_ra = b;  row_we = 1'b0; row_wa = b;  row_wd = row_q;
    kv_ra  = {b, s}; kv_we = 1'b0; kv_wa = {b, s}; kv_wd = {key_q, val_q};
    case (ctl.op)
      OP_INIT: begin
        dir_we = 1'b1; dir_wa = '0;
        ld_we  = 1'b1; ld_wa  = '0; ld_wd = '0;
        row_we = 1'b1; row_wa = '0; row_wd = '0;
      end
      OP_DIR_RD: dir_ra = key_q[DIR_W-1:0] & dir_mask(depth);
      OP_BKT_RD: begin
        row_ra = dir_rdata;
        ld_ra  = dir_rdata;
      end
      OP_REMOVE: begin
        row_we = hit;
        row_wd = row_q & ~(SLOTS'(1) << hit_slot);
      end
      OP_OVERWRITE: begin
        kv_we = 1'b1; kv_wa = {b, hit_slot};
      end
      OP_STORE: begin
        kv_we  = 1'b1; kv_wa = {b, free_slot};
        row_we = 1'b1; row_wd = row_q | (SLOTS'(1) << free_slot);
      end
      OP_SPLIT_BEGIN: ld_we = 1'b1;
      OP_DBL_WR: begin
        dir_we = 1'b1; dir_wa = i + len; dir_wd = dir_rdata;
      end
      OP_NEW_LD: begin
        ld_we = 1'b1; ld_wa = nb;
      end
      OP_MOVE_WR: begin
        kv_we = move_hit; kv_wa = {nb, put}; kv_wd = kv_rdata;
      end
      OP_ROW_WR_OLD: row_we = 1'b1;
      OP_ROW_WR_NEW: begin
        row_we = 1'b1; row_wa = nb; row_wd = new_row;
      end
      OP_RP_WR: begin
        dir_we = (dir_rdata == b) && i[ldb];
        dir_wd = nb;
      end
      default: begin
      end
    endcase
  end

  // Memory write and registered read ports.
  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    dir_rdata <= dir_mem[dir_ra];
    if (ld_we) ld_mem[ld_wa] <= ld_wd;
    ld_rdata <= ld_mem[ld_ra];
    if (row_we) row_mem[row_wa] <= row_wd;
    row_rdata <= row_mem[row_ra];
    if (kv_we) kv_mem[kv_wa] <= kv_wd;
    kv_rdata <= kv_mem[kv_ra];
  end

  // Control registers: capacity, depth, bucket count, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CAP_RESET;
      depth     <= '0;
      bcount    <= COUNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) cap <= cfg_wr_data;
      if (ctl.op == OP_SPLIT_BEGIN) bcount <= bcount + COUNT_W'(1);
      if (ctl.op == OP_DBL_WR && stat.i_last) depth <= depth + DEPTH_W'(1);
      if (result_op) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers for scan, split and result.
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd_q <= command;
        key_q <= key;
        val_q <= write_value;
      end
      OP_BKT_RD: begin
        b          <= dir_rdata;
        s          <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        used       <= '0;
      end
      OP_ROW_LATCH: begin
        row_q <= row_rdata;
        ldb   <= ld_rdata;
      end
      OP_SLOT_CMP: begin
        if (slot_match) begin
          hit      <= 1'b1;
          hit_slot <= s;
          hit_val  <= kv_rdata[VAL_W-1:0];
        end
        if (row_q[s]) begin
          used <= used + USED_W'(1);
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_slot  <= s;
        end
        s <= s + SLOT_W'(1);
      end
      OP_SPLIT_BEGIN: begin
        nb <= bcount[DIR_W-1:0];
        i  <= '0;
      end
      OP_DBL_WR: i <= i + DIR_W'(1);
      OP_NEW_LD: begin
        s       <= '0;
        put     <= '0;
        new_row <= '0;
      end
      OP_MOVE_WR: begin
        if (move_hit) begin
          new_row[put] <= 1'b1;
          row_q[s]     <= 1'b0;
          put          <= put + SLOT_W'(1);
        end
        s <= s + SLOT_W'(1);
      end
      OP_ROW_WR_NEW: i <= '0;
      OP_RP_WR: i <= i + DIR_W'(1);
      default: begin
      end
    endcase
  end

  // Result register, held while the output is stalled.
  always_ff @(posedge clk) begin
    if (result_op) begin
      global_depth <= depth;
      bucket_count <= bcount;
      read_value   <= '0;
      case (ctl.op)
        OP_FIND_DONE: begin
          status     <= hit ? ST_OK : ST_MISSING;
          read_value <= hit ? hit_val : '0;
        end
        OP_REMOVE: status <= hit ? ST_OK : ST_MISSING;
        OP_FULL:   status <= ST_FULL;
        default:   status <= ST_OK;
      endcase
    end
  end

  // The global depth never passes MAX_DEPTH.
  a_depth_limit: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(MAX_DEPTH))
    else $error("global depth beyond limit");

  // Bucket count stays between one and the directory size.
  a_bcount_range: assert property (@(posedge clk) disable iff (rst)
    (bcount != '0) && (bcount <= COUNT_W'(DIR_N)))
    else $error("bucket count out of range");

  // An overwrite is only issued after the scan found the key.
  a_overwrite_hit: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_OVERWRITE) |-> hit)
    else $error("overwrite without a matching slot");

  // Each split allocates exactly one bucket.
  a_split_count: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_SPLIT_BEGIN) |=> (bcount == $past(bcount) + COUNT_W'(1)))
    else $error("split did not allocate a bucket");

endmodule

/* design/extendible_hash_table.sv */
// Extendible hash table: find, insert and remove over 32-bit keys and values.
// One transaction is in progress at a time; the bucket scan, which reads and
// compares each slot in turn, sets the rate. Synchronous reset, then table
// initialisation.
// Depends on ehash_pkg, ehash_ctrl and ehash_dp.
module extendible_hash_table
  import ehash_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CAP_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [KEY_W-1:0]   key,
  input  logic [VAL_W-1:0]   write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [VAL_W-1:0]   read_value,
  output logic [DEPTH_W-1:0] global_depth,
  output logic [COUNT_W-1:0] bucket_count
);

  dp_cmd_t    ctl;
  dp_status_t stat;

  // Sequencer.
  ehash_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Storage and arithmetic.
  ehash_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .command      (command),
    .key          (key),
    .write_value  (write_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .read_value   (read_value),
    .global_depth (global_depth),
    .bucket_count (bucket_count)
  );

endmodule

/* dv/tb.sv */
// Self-checking testbench for extendible_hash_table: a directed table, then
// random find, insert, remove and spare-command traffic checked against an in-bench model.
// Depends on ehash_pkg and the extendible_hash_table RTL.
`timescale 1ns / 100ps

module tb;
  import ehash_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [VAL_W-1:0]   value;
    logic [DEPTH_W-1:0] depth;
    logic [COUNT_W-1:0] count;
  } table_result_t;

  typedef struct {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    bit               typed;
    table_result_t    res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]   cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         command = CMD_FIND;
  logic [KEY_W-1:0]   key = '0;
  logic [VAL_W-1:0]   write_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [VAL_W-1:0]   read_value;
  logic [DEPTH_W-1:0] global_depth;
  logic [COUNT_W-1:0] bucket_count;

  extendible_hash_table uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .key(key),
    .write_value(write_value), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .read_value(read_value), .global_depth(global_depth),
    .bucket_count(bucket_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the table contents.
  logic [DIR_W-1:0] mdl_dir[DIR_N];
  int unsigned      mdl_ldepth[DIR_N];
  bit               mdl_valid[DIR_N*SLOTS];
  logic [KEY_W-1:0] mdl_key[DIR_N*SLOTS];
  logic [VAL_W-1:0] mdl_val[DIR_N*SLOTS];
  int unsigned      mdl_depth = 0;
  int unsigned      mdl_buckets = 1;
  logic [CAP_W-1:0] mdl_cap = CAP_RESET;

  table_result_t pending_results[$];
  int unsigned   mismatches = 0;
  bit            quiet_period = 1'b0;
  bit            hold_request = 1'b0;
  logic [KEY_W-1:0] key_pool[4];

  initial begin
    for (int i = 0; i < DIR_N; i++) begin
      mdl_dir[i] = '0;
      mdl_ldepth[i] = 0;
    end
    for (int i = 0; i < DIR_N*SLOTS; i++) mdl_valid[i] = 1'b0;
  end

  function automatic int bucket_of(logic [KEY_W-1:0] k);
    return mdl_dir[k & ((32'd1 << mdl_depth) - 1)];
  endfunction

  function automatic int slot_holding(int b, logic [KEY_W-1:0] k);
    for (int s = 0; s < SLOTS; s++)
      if (mdl_valid[b*SLOTS+s] && mdl_key[b*SLOTS+s] == k) return b*SLOTS + s;
    return -1;
  endfunction

  // Split bucket b: raise its depth, grow the directory if needed, move keys.
  function automatic void split_bucket(int b);
    int unsigned old_d, nb, put, len;
    old_d = mdl_ldepth[b];
    put = 0;
    mdl_ldepth[b] = old_d + 1;
    if (old_d + 1 > mdl_depth) begin
      len = 1 << mdl_depth;
      for (int i = 0; i < len; i++) mdl_dir[i+len] = mdl_dir[i];
      mdl_depth++;
    end
    nb = mdl_buckets & (DIR_N - 1);
    mdl_buckets++;
    mdl_ldepth[nb] = old_d + 1;
    for (int s = 0; s < SLOTS; s++) mdl_valid[nb*SLOTS+s] = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      if (mdl_valid[b*SLOTS+s] && mdl_key[b*SLOTS+s][old_d]) begin
        mdl_valid[nb*SLOTS+put] = 1'b1;
        mdl_key[nb*SLOTS+put] = mdl_key[b*SLOTS+s];
        mdl_val[nb*SLOTS+put] = mdl_val[b*SLOTS+s];
        put++;
        mdl_valid[b*SLOTS+s] = 1'b0;
      end
    end
    for (int i = 0; i < (1 << mdl_depth); i++)
      if (mdl_dir[i] == DIR_W'(b) && (i >> old_d) % 2 == 1)
        mdl_dir[i] = DIR_W'(nb);
  endfunction

  function automatic logic [1:0] insert_entry(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int unsigned cap, used, free_s;
    int b, p;
    cap = (mdl_cap == 0) ? 1 : ((mdl_cap > SLOTS) ? SLOTS : mdl_cap);
    forever begin
      b = bucket_of(k);
      p = slot_holding(b, k);
      if (p >= 0) begin
        mdl_val[p] = v;
        return ST_OK;
      end
      used = 0;
      free_s = SLOTS;
      for (int s = 0; s < SLOTS; s++) begin
        if (mdl_valid[b*SLOTS+s]) used++;
        else if (free_s == SLOTS) free_s = s;
      end
      if (used < cap && free_s < SLOTS) begin
        mdl_valid[b*SLOTS+free_s] = 1'b1;
        mdl_key[b*SLOTS+free_s] = k;
        mdl_val[b*SLOTS+free_s] = v;
        return ST_OK;
      end
      if (mdl_ldepth[b] >= MAX_DEPTH) return ST_FULL;
      split_bucket(b);
    end
  endfunction

  // Applies one command to the mirror and returns what the block should give.
  function automatic table_result_t hash_table_step(logic [1:0] c, logic [KEY_W-1:0] k,
                                                    logic [VAL_W-1:0] v);
    table_result_t r;
    int p;
    r.status = ST_MISSING;
    r.value = '0;
    if (c == CMD_INSERT) begin
      r.status = insert_entry(k, v);
    end else begin
      p = slot_holding(bucket_of(k), k);
      if (p >= 0) begin
        r.status = ST_OK;
        if (c == CMD_REMOVE) mdl_valid[p] = 1'b0;
        else r.value = mdl_val[p];
      end
    end
    r.depth = mdl_depth[DEPTH_W-1:0];
    r.count = mdl_buckets[COUNT_W-1:0];
    return r;
  endfunction

  // Offers one transaction, recording its expected result, and waits for acceptance.
  task automatic send_command(logic [1:0] c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                              bit typed, table_result_t typed_res);
    table_result_t r;
    if (!quiet_period && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    r = hash_table_step(c, k, v);
    pending_results = {pending_results, (typed ? typed_res : r)};
    in_valid <= 1'b1;
    command <= c;
    key <= k;
    write_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_and_configure(logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    mdl_cap = cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    k = key_pool[$urandom_range(3)];
    if ($urandom_range(99) < 75) k[7:0] = 8'($urandom_range(255));
    else k = $urandom;
    return k;
  endfunction

  function automatic logic [1:0] random_command();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return CMD_INSERT;
    if (r < 75) return CMD_FIND;
    if (r < 95) return CMD_REMOVE;
    return CMD_SPARE;
  endfunction

  // Receiver: random stalls, a quiet stretch, and one long hold-off.
  int unsigned hold_cycles = 0;
  always @(posedge clk) begin
    table_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d value %h", status,
                                       read_value);
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status || read_value !== exp_r.value ||
            global_depth !== exp_r.depth || bucket_count !== exp_r.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d val %h gd %0d bc %0d, got st %0d val %h gd %0d bc %0d",
                     exp_r.status, exp_r.value, exp_r.depth, exp_r.count,
                     status, read_value, global_depth, bucket_count);
        end
      end
    end
    if (hold_request && hold_cycles < 400) begin
      hold_cycles <= hold_cycles + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_period && ($urandom_range(99) < 11);
    end
  end

  stim_row_t directed[$];
  logic [CAP_W-1:0] caps[5] = '{4'd15, 4'd3, 4'd0, 4'd8, 4'd1};

  function automatic void add_row(logic [1:0] c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                                  bit typed, logic [1:0] st, logic [VAL_W-1:0] rv,
                                  logic [DEPTH_W-1:0] gd, logic [COUNT_W-1:0] bc);
    stim_row_t row;
    row.cmd = c; row.key = k; row.val = v; row.typed = typed;
    row.res = '{st, rv, gd, bc};
    directed = {directed, row};
  endfunction

  initial begin
    for (int i = 0; i < 4; i++) key_pool[i] = $urandom;
    // Empty table, extremes, overwrite, the unused command, and removal.
    add_row(CMD_FIND,   32'h0, 32'h0, 1, ST_MISSING, 32'h0, 3'd0, 7'd1);
    add_row(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0, 1, ST_MISSING, 32'h0, 3'd0, 7'd1);
    add_row(CMD_INSERT, 32'h0, 32'hFFFF_FFFF, 1, ST_OK, 32'h0, 3'd0, 7'd1);
    add_row(CMD_FIND,   32'h0, 32'h1234_5678, 1, ST_OK, 32'hFFFF_FFFF, 3'd0, 7'd1);
    add_row(CMD_INSERT, 32'h0, 32'h0, 1, ST_OK, 32'h0, 3'd0, 7'd1);
    add_row(CMD_SPARE,  32'h0, 32'hFFFF_FFFF, 1, ST_OK, 32'h0, 3'd0, 7'd1);
    add_row(CMD_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 1, ST_OK, 32'h0, 3'd0, 7'd1);
    add_row(CMD_FIND,   32'hFFFF_FFFF, 32'h0, 1, ST_OK, 32'hA5A5_5A5A, 3'd0, 7'd1);
    add_row(CMD_REMOVE, 32'h0, 32'h0, 1, ST_OK, 32'h0, 3'd0, 7'd1);
    add_row(CMD_REMOVE, 32'h0, 32'h0, 1, ST_MISSING, 32'h0, 3'd0, 7'd1);
    // Keys sharing six low bits force splits up to the depth limit.
    for (int i = 0; i < 10; i++)
      add_row(CMD_INSERT, 32'(i) << 6, 32'(i) ^ 32'h5555_AAAA, 0, ST_OK, '0, '0, '0);
    add_row(CMD_FIND, 32'h0000_0100, 32'h0, 0, ST_OK, '0, '0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_command(directed[i].cmd, directed[i].key, directed[i].val,
                   directed[i].typed, directed[i].res);

    for (int ph = 0; ph < 5; ph++) begin
      drain_and_configure(caps[ph]);
      quiet_period = (ph == 1);
      if (ph == 2) hold_request = 1'b1;
      for (int n = 0; n < 186; n++)
        send_command(random_command(), random_key(), $urandom, 0, '0);
      quiet_period = 1'b0;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
